### hw/rtl/pixel_channel_bit_packer_defines.svh
// Assertion helpers shared by the packer RTL.
`ifndef PIXEL_CHANNEL_BIT_PACKER_DEFINES_SVH
`define PIXEL_CHANNEL_BIT_PACKER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PCBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcbp check failed");

// Consequent checked in the cycle after the antecedent.
`define PCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcbp check failed");

`endif

### hw/rtl/pcbp_pkg.sv
package pcbp_pkg;

    localparam int WORD_W    = 32;
    localparam int CHAN_W    = 8;
    localparam int BYTE_W    = 8;
    localparam int NUM_CHAN  = 4;
    localparam int NUM_BYTES = WORD_W / BYTE_W;
    localparam int IDX_W     = $clog2(WORD_W);
    localparam int BSEL_W    = $clog2(NUM_BYTES);
    localparam int COUNT_W   = 3;
    localparam int CFG_IDX_W = 3;

    localparam int MAX_CHANNELS_DEF = 4;
    localparam int MAX_BYTES_DEF    = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MASK_ZERO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_ONE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_TWO      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_THREE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LITTLE_ENDIAN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNPACK_MODE   = 3'd7;

    localparam logic [WORD_W-1:0]  MASK_ZERO_RST     = 32'h0000_F800;
    localparam logic [WORD_W-1:0]  MASK_ONE_RST      = 32'h0000_07E0;
    localparam logic [WORD_W-1:0]  MASK_TWO_RST      = 32'h0000_001F;
    localparam logic [WORD_W-1:0]  MASK_THREE_RST    = 32'h0000_0000;
    localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST = 3'd3;
    localparam logic [COUNT_W-1:0] BYTE_COUNT_RST    = 3'd2;
    localparam logic               LITTLE_ENDIAN_RST = 1'b1;
    localparam logic               UNPACK_MODE_RST   = 1'b0;

    // top bit of a channel field that lands on bit 7
    localparam logic [IDX_W-1:0] CHAN_TOP = IDX_W'(CHAN_W - 1);

    typedef struct packed {
        logic             active;
        logic [IDX_W-1:0] hb;
        logic [IDX_W-1:0] lb;
    } field_info_t;

    // highest set bit, binary search
    function automatic logic [IDX_W-1:0] msb_index(input logic [WORD_W-1:0] m);
        logic [WORD_W-1:0] x;
        logic [IDX_W-1:0]  idx;
        x   = m;
        idx = '0;
        for (int s = IDX_W - 1; s >= 0; s--) begin
            if ((x >> (1 << s)) != '0) begin
                idx[s] = 1'b1;
                x      = x >> (1 << s);
            end
        end
        return idx;
    endfunction

    // lowest set bit: isolate it, then encode the one-hot word
    function automatic logic [IDX_W-1:0] lsb_index(input logic [WORD_W-1:0] m);
        logic [WORD_W-1:0] iso;
        logic [IDX_W-1:0]  idx;
        iso = m & (~m + 1'b1);
        idx = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (iso[b]) begin
                idx = idx | IDX_W'(b);
            end
        end
        return idx;
    endfunction

    // byte k takes byte k (little) or nby-1-k (big); bytes past nby are zero
    function automatic logic [WORD_W-1:0] reorder_bytes(input logic [WORD_W-1:0]  w,
                                                        input logic [COUNT_W-1:0] nby,
                                                        input logic               le);
        logic [WORD_W-1:0]  r;
        logic [COUNT_W-1:0] src;
        logic [BSEL_W-1:0]  sel;
        r = '0;
        for (int k = 0; k < NUM_BYTES; k++) begin
            src = le ? COUNT_W'(k) : (nby - 1'b1 - COUNT_W'(k));
            sel = src[BSEL_W-1:0];
            if (COUNT_W'(k) < nby) begin
                r[k*BYTE_W +: BYTE_W] = w[sel*BYTE_W +: BYTE_W];
            end
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] byte_keep(input logic [COUNT_W-1:0] nby);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int k = 0; k < NUM_BYTES; k++) begin
            if (COUNT_W'(k) < nby) begin
                r[k*BYTE_W +: BYTE_W] = '1;
            end
        end
        return r;
    endfunction

endpackage

### hw/rtl/pcbp_lane.sv
module pcbp_lane (
    input  logic [pcbp_pkg::WORD_W-1:0] mask,
    input  pcbp_pkg::field_info_t       info,
    input  logic [pcbp_pkg::CHAN_W-1:0] value,
    input  logic [pcbp_pkg::WORD_W-1:0] word,
    output logic [pcbp_pkg::WORD_W-1:0] contrib,
    output logic [pcbp_pkg::CHAN_W-1:0] chan
);

    logic [pcbp_pkg::IDX_W-1:0]  span;
    logic [pcbp_pkg::IDX_W-1:0]  down;
    logic [pcbp_pkg::CHAN_W-1:0] shifted;
    logic [pcbp_pkg::WORD_W-1:0] field;
    logic [pcbp_pkg::WORD_W-1:0] aligned;

    always_comb
    begin
        span = info.hb - info.lb;
        // fields of 8 bits or more take the whole channel value
        down    = (span >= pcbp_pkg::CHAN_TOP) ? '0 : (pcbp_pkg::CHAN_TOP - span);
        shifted = value >> down;
        contrib = info.active ? (pcbp_pkg::WORD_W'(shifted) << info.lb) : '0;

        field = word & mask;
        if (info.hb <= pcbp_pkg::CHAN_TOP) begin
            aligned = field << (pcbp_pkg::CHAN_TOP - info.hb);
        end
        else begin
            aligned = field >> (info.hb - pcbp_pkg::CHAN_TOP);
        end
        chan = info.active ? aligned[pcbp_pkg::CHAN_W-1:0] : '0;
    end

endmodule

### hw/rtl/pixel_channel_bit_packer.sv
// Pixel channel bit packer: converts one pixel per clock between four 8-bit
// channels and a packed word of one to four bytes, driven by a per-channel field
// mask, a byte order and a pack/unpack mode. The datapath is a three-stage
// pipeline (field decode and byte assembly, per-channel shift, merge and byte
// order into the output register); a new word can be accepted every cycle and
// throughput is one pixel per clock, limited only by out_ready. Each stage
// holds its word under backpressure and in_ready stays high while any stage
// has a bubble. Configuration must be written only while the pipeline is
// empty; the block itself does not enforce this.
`include "pixel_channel_bit_packer_defines.svh"

module pixel_channel_bit_packer #(
    parameter int MAX_CHANNELS = pcbp_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_BYTES    = pcbp_pkg::MAX_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_we,
    input  logic [pcbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcbp_pkg::WORD_W-1:0]    cfg_data,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [pcbp_pkg::CHAN_W-1:0]    chan_in_zero,
    input  logic [pcbp_pkg::CHAN_W-1:0]    chan_in_one,
    input  logic [pcbp_pkg::CHAN_W-1:0]    chan_in_two,
    input  logic [pcbp_pkg::CHAN_W-1:0]    chan_in_three,
    input  logic [pcbp_pkg::WORD_W-1:0]    bytes_in,
    input  logic                           last_pixel,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [pcbp_pkg::WORD_W-1:0]    bytes_out,
    output logic [pcbp_pkg::CHAN_W-1:0]    chan_out_zero,
    output logic [pcbp_pkg::CHAN_W-1:0]    chan_out_one,
    output logic [pcbp_pkg::CHAN_W-1:0]    chan_out_two,
    output logic [pcbp_pkg::CHAN_W-1:0]    chan_out_three,
    output logic                           last_out
);

    localparam int NCH = pcbp_pkg::NUM_CHAN;
    localparam int WW  = pcbp_pkg::WORD_W;
    localparam int CW  = pcbp_pkg::CHAN_W;
    localparam int NW  = pcbp_pkg::COUNT_W;

    // configuration
    logic [WW-1:0] mask_reg [NCH];
    logic [NW-1:0] channel_count_reg;
    logic [NW-1:0] byte_count_reg;
    logic          little_endian_reg;
    logic          unpack_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mask_reg[0]       <= pcbp_pkg::MASK_ZERO_RST;
            mask_reg[1]       <= pcbp_pkg::MASK_ONE_RST;
            mask_reg[2]       <= pcbp_pkg::MASK_TWO_RST;
            mask_reg[3]       <= pcbp_pkg::MASK_THREE_RST;
            channel_count_reg <= pcbp_pkg::CHANNEL_COUNT_RST;
            byte_count_reg    <= pcbp_pkg::BYTE_COUNT_RST;
            little_endian_reg <= pcbp_pkg::LITTLE_ENDIAN_RST;
            unpack_mode_reg   <= pcbp_pkg::UNPACK_MODE_RST;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                pcbp_pkg::REG_MASK_ZERO:     mask_reg[0]       <= cfg_data;
                pcbp_pkg::REG_MASK_ONE:      mask_reg[1]       <= cfg_data;
                pcbp_pkg::REG_MASK_TWO:      mask_reg[2]       <= cfg_data;
                pcbp_pkg::REG_MASK_THREE:    mask_reg[3]       <= cfg_data;
                pcbp_pkg::REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[NW-1:0];
                pcbp_pkg::REG_BYTE_COUNT:    byte_count_reg    <= cfg_data[NW-1:0];
                pcbp_pkg::REG_LITTLE_ENDIAN: little_endian_reg <= cfg_data[0];
                pcbp_pkg::REG_UNPACK_MODE:   unpack_mode_reg   <= cfg_data[0];
            endcase
        end
    end

    logic [NW-1:0] nch;
    logic [NW-1:0] nby;

    always_comb
    begin
        if (channel_count_reg == '0) begin
            nch = NW'(1);
        end
        else if (channel_count_reg > NW'(MAX_CHANNELS)) begin
            nch = NW'(MAX_CHANNELS);
        end
        else begin
            nch = channel_count_reg;
        end

        if (byte_count_reg == '0) begin
            nby = NW'(1);
        end
        else if (byte_count_reg > NW'(MAX_BYTES)) begin
            nby = NW'(MAX_BYTES);
        end
        else begin
            nby = byte_count_reg;
        end
    end

    // stall control: a stage moves when it is empty or the next one moves
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // stage 1: field decode, byte assembly for unpack
    logic [CW-1:0]         chan_in [NCH];
    pcbp_pkg::field_info_t info_next [NCH];
    pcbp_pkg::field_info_t info_reg  [NCH];
    logic [CW-1:0]         val1_reg  [NCH];
    logic [WW-1:0]         word1_reg;
    logic                  last1_reg;

    assign chan_in[0] = chan_in_zero;
    assign chan_in[1] = chan_in_one;
    assign chan_in[2] = chan_in_two;
    assign chan_in[3] = chan_in_three;

    always_comb
    begin
        for (int i = 0; i < NCH; i++) begin
            info_next[i].active = (i < MAX_CHANNELS) && (NW'(i) < nch) && (mask_reg[i] != '0);
            info_next[i].hb     = pcbp_pkg::msb_index(mask_reg[i]);
            info_next[i].lb     = pcbp_pkg::lsb_index(mask_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) begin
            for (int i = 0; i < NCH; i++) begin
                info_reg[i] <= info_next[i];
                val1_reg[i] <= chan_in[i];
            end
            // the byte order map is its own inverse
            word1_reg <= pcbp_pkg::reorder_bytes(bytes_in, nby, little_endian_reg);
            last1_reg <= last_pixel;
        end
    end

    // stage 2: per-channel shifts
    logic [WW-1:0] contrib      [NCH];
    logic [CW-1:0] chan_x       [NCH];
    logic [WW-1:0] contrib2_reg [NCH];
    logic [CW-1:0] chan2_reg    [NCH];
    logic          last2_reg;

    for (genvar g = 0; g < NCH; g++) begin : g_lane
        if (g < MAX_CHANNELS) begin : g_used
            pcbp_lane u_lane (
                .mask    (mask_reg[g]),
                .info    (info_reg[g]),
                .value   (val1_reg[g]),
                .word    (word1_reg),
                .contrib (contrib[g]),
                .chan    (chan_x[g])
            );
        end
        else begin : g_unused
            assign contrib[g] = '0;
            assign chan_x[g]  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2) begin
            for (int i = 0; i < NCH; i++) begin
                contrib2_reg[i] <= contrib[i];
                chan2_reg[i]    <= chan_x[i];
            end
            last2_reg <= last1_reg;
        end
    end

    // stage 3: merge, byte order, mode select
    logic [WW-1:0] merged;
    logic [WW-1:0] bytes3_reg;
    logic [CW-1:0] chan3_reg [NCH];
    logic          last3_reg;

    always_comb
    begin
        merged = '0;
        for (int i = 0; i < NCH; i++) begin
            merged = merged | contrib2_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3) begin
            bytes3_reg <= unpack_mode_reg ? '0
                        : pcbp_pkg::reorder_bytes(merged, nby, little_endian_reg);
            for (int i = 0; i < NCH; i++) begin
                chan3_reg[i] <= unpack_mode_reg ? chan2_reg[i] : '0;
            end
            last3_reg <= last2_reg;
        end
    end

    assign out_valid      = v3_reg;
    assign bytes_out      = bytes3_reg;
    assign chan_out_zero  = chan3_reg[0];
    assign chan_out_one   = chan3_reg[1];
    assign chan_out_two   = chan3_reg[2];
    assign chan_out_three = chan3_reg[3];
    assign last_out       = last3_reg;

    `PCBP_ASSERT_NOW(a_pack_no_chan, clk, rst_n, out_valid && !unpack_mode_reg,
        (chan_out_zero | chan_out_one | chan_out_two | chan_out_three) == '0)
    `PCBP_ASSERT_NOW(a_unpack_no_bytes, clk, rst_n, out_valid && unpack_mode_reg,
        bytes_out == '0)
    `PCBP_ASSERT_NOW(a_bytes_in_count, clk, rst_n, out_valid,
        (bytes_out & ~pcbp_pkg::byte_keep(nby)) == '0)
    `PCBP_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_valid && in_ready, v1_reg)
    `PCBP_ASSERT_NEXT(a_stall_keeps, clk, rst_n, v3_reg && !out_ready, v3_reg)

endmodule
